FILE: rtl/tks_pkg.sv
// ----------------------------------------------------------------------------
// tks_pkg - shared types and constants for the streaming top-k selector
// Sizes of the cell chain, the token carried between cells, the per-cell
// command group and the sequencer states.
// ----------------------------------------------------------------------------
package tks_pkg;

  // Number of cells in the chain (largest supported k)
  localparam int MAX_KEEP = 16;

  // Fixed field widths
  localparam int VAL_W   = 32;
  localparam int RANK_W  = 4;
  localparam int CFG_W   = 5;
  localparam int OUT_TDATA_W = ((VAL_W + RANK_W + 7) / 8) * 8;

  // Widths derived from the chain length
  localparam int IDX_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int K_W   = $clog2(MAX_KEEP + 1);
  localparam int CNT_W = K_W + 1;

  // Status codes of a result beat
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_SHORT = 1'b1;

  // Value/index token handed from cell to cell
  typedef struct packed {
    logic                    vld;
    logic signed [VAL_W-1:0] val;
    logic [IDX_W-1:0]        idx;
  } tok_t;

  // Per-cell command group
  typedef struct packed {
    logic we;       // write the stored value
    logic load;     // start a rank pass: seed ring copy, clear rank count
    logic rank_en;  // rank pass step: count and shift the ring
  } cmd_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CLOSE,
    ST_RANK,
    ST_EMIT
  } state_e;

endpackage

FILE: rtl/tks_cell.sv
// ----------------------------------------------------------------------------
// tks_cell - one slot of the top-k store
// Holds one kept value. A min token ripples through the chain one cell per
// cycle; a ring copy of the values rotates during the rank pass so that each
// cell counts how many kept values outrank its own.
// ----------------------------------------------------------------------------
module tks_cell (
  input  logic                              clk_i,
  input  logic [tks_pkg::IDX_W-1:0]         cell_idx_i,
  input  tks_pkg::cmd_t                     cmd_i,
  input  logic signed [tks_pkg::VAL_W-1:0]  wr_data_i,
  input  tks_pkg::tok_t                     tok_i,
  output tks_pkg::tok_t                     tok_o,
  input  tks_pkg::tok_t                     circ_i,
  output tks_pkg::tok_t                     circ_o,
  output logic signed [tks_pkg::VAL_W-1:0]  val_o,
  output logic [tks_pkg::IDX_W-1:0]         rank_o
);

  logic signed [tks_pkg::VAL_W-1:0] val_q;
  tks_pkg::tok_t                    tok_q, tok_d;
  tks_pkg::tok_t                    circ_q, circ_d;
  tks_pkg::tok_t                    own;
  logic [tks_pkg::IDX_W-1:0]        rank_q, rank_d;
  logic                             hit;

  assign own = '{vld: 1'b1, val: val_q, idx: cell_idx_i};

  // Running minimum: strict compare keeps the lowest index on ties
  always_comb begin
    if (!tok_i.vld || (val_q < tok_i.val)) begin
      tok_d = own;
    end else begin
      tok_d = tok_i;
    end
  end

  // Another value outranks ours if larger, or equal at a lower index
  assign hit = circ_q.vld &&
               ((circ_q.val > val_q) ||
                ((circ_q.val == val_q) && (circ_q.idx < cell_idx_i)));

  // Ring copy and rank count
  always_comb begin
    circ_d = circ_q;
    rank_d = rank_q;
    if (cmd_i.load) begin
      circ_d = own;
      rank_d = '0;
    end else if (cmd_i.rank_en) begin
      circ_d = circ_i;
      rank_d = rank_q + tks_pkg::IDX_W'(hit);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      val_q <= wr_data_i;
    end
    tok_q  <= tok_d;
    circ_q <= circ_d;
    rank_q <= rank_d;
  end

  assign tok_o  = tok_q;
  assign circ_o = circ_q;
  assign val_o  = val_q;
  assign rank_o = rank_q;

endmodule

FILE: rtl/streaming_top_k_select.sv
// ----------------------------------------------------------------------------
// streaming_top_k_select - keeps the k largest signed values of a stream
// On the beat marked last the run closes: an error beat if fewer than 2k
// values came in, else the k kept values, largest first.
//
//   channel  | dir | beat contents
//   ---------+-----+---------------------------------------------------------
//   s_axis   | in  | tdata[31:0] value, tlast last_item
//   m_axis   | out | tdata[31:0] kept_value, [35:32] rank, [39:36] zero;
//            |     | tuser status; tlast last_result
//   cfg      | in  | cfg_we_i / cfg_wdata_i: keep_count (5 bits)
//
// A value while the store fills (fewer than k taken) goes straight to the next
// free slot; later values go through a minimum search that ripples through k
// cells. Closing a full run starts a rank pass around the cell ring; a short
// run skips the rank pass. Then one beat goes out per cycle while
// m_axis_tready_i is high.
// Reset clears the control state and sets keep_count to 1; stored values are
// undefined until written. Output back-pressure holds the emission; input
// is taken only in the idle state.
// ----------------------------------------------------------------------------
module streaming_top_k_select (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [tks_pkg::CFG_W-1:0]           cfg_wdata_i,
  // input stream
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [tks_pkg::VAL_W-1:0]           s_axis_tdata_i,   // [31:0] value
  input  logic                                s_axis_tlast_i,
  // result stream
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [tks_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,   // [31:0] kept_value,
                                                                // [35:32] rank
  output logic [0:0]                          m_axis_tuser_o,   // [0] status
  output logic                                m_axis_tlast_o
);

  localparam int PAD_W = tks_pkg::OUT_TDATA_W - tks_pkg::VAL_W - tks_pkg::RANK_W;

  tks_pkg::state_e                    state_q, state_d;
  logic [tks_pkg::CFG_W-1:0]          keep_q;
  logic [tks_pkg::K_W-1:0]            k_eff;
  logic [tks_pkg::K_W-1:0]            k_q, k_d;
  logic [tks_pkg::IDX_W-1:0]          km1;
  logic signed [tks_pkg::VAL_W-1:0]   v_q, v_d;
  logic                               last_q, last_d;
  logic [tks_pkg::CNT_W-1:0]          cnt_q, cnt_d, cnt_inc;
  logic [tks_pkg::IDX_W-1:0]          step_q, step_d;
  logic [tks_pkg::IDX_W-1:0]          r_q, r_d;
  logic                               err_q, err_d;

  // output register
  logic                               out_vld_q;
  logic signed [tks_pkg::VAL_W-1:0]   out_val_q;
  logic [tks_pkg::RANK_W-1:0]         out_rank_q;
  logic                               out_status_q;
  logic                               out_last_q;
  logic                               out_free, out_load;
  logic signed [tks_pkg::VAL_W-1:0]   load_val;
  logic [tks_pkg::RANK_W-1:0]         load_rank;
  logic                               load_status, load_last;

  // cell chain
  logic                               wr_vld;
  logic [tks_pkg::IDX_W-1:0]          wr_idx;
  logic signed [tks_pkg::VAL_W-1:0]   wr_data;
  logic                               load_cmd, rank_cmd;
  tks_pkg::cmd_t                      cmd   [tks_pkg::MAX_KEEP];
  tks_pkg::tok_t                      tok_in  [tks_pkg::MAX_KEEP];
  tks_pkg::tok_t                      tok_out [tks_pkg::MAX_KEEP];
  tks_pkg::tok_t                      circ_in  [tks_pkg::MAX_KEEP];
  tks_pkg::tok_t                      circ_out [tks_pkg::MAX_KEEP];
  logic signed [tks_pkg::VAL_W-1:0]   cell_val  [tks_pkg::MAX_KEEP];
  logic [tks_pkg::IDX_W-1:0]          cell_rank [tks_pkg::MAX_KEEP];
  tks_pkg::tok_t                      min_tok;
  logic signed [tks_pkg::VAL_W-1:0]   emit_val;

  logic                               in_acc;

  // Effective k: zero reads as one, large values saturate
  always_comb begin
    if (keep_q == '0) begin
      k_eff = tks_pkg::K_W'(1);
    end else if (int'(keep_q) > tks_pkg::MAX_KEEP) begin
      k_eff = tks_pkg::K_W'(tks_pkg::MAX_KEEP);
    end else begin
      k_eff = tks_pkg::K_W'(keep_q);
    end
  end

  assign km1     = tks_pkg::IDX_W'(k_q - tks_pkg::K_W'(1));
  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + tks_pkg::CNT_W'(1);
  assign s_axis_tready_o = (state_q == tks_pkg::ST_IDLE);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_vld_q || m_axis_tready_i;
  assign min_tok  = tok_out[km1];

  // Sequencer: next state and chain commands
  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    v_d      = v_q;
    last_d   = last_q;
    cnt_d    = cnt_q;
    step_d   = step_q;
    r_d      = r_q;
    err_d    = err_q;
    wr_vld   = 1'b0;
    wr_idx   = min_tok.idx;
    wr_data  = v_q;
    load_cmd = 1'b0;
    rank_cmd = 1'b0;
    out_load = 1'b0;
    case (state_q)
      tks_pkg::ST_IDLE: begin
        if (in_acc) begin
          k_d    = k_eff;
          v_d    = s_axis_tdata_i;
          last_d = s_axis_tlast_i;
          cnt_d  = cnt_inc;
          step_d = '0;
          if (cnt_q < tks_pkg::CNT_W'(k_eff)) begin
            // store still filling: write the next free slot
            wr_vld  = 1'b1;
            wr_idx  = cnt_q[tks_pkg::IDX_W-1:0];
            wr_data = s_axis_tdata_i;
            if (s_axis_tlast_i) begin
              state_d = tks_pkg::ST_CLOSE;
            end
          end else begin
            state_d = tks_pkg::ST_SEARCH;
          end
        end
      end
      tks_pkg::ST_SEARCH: begin
        if (step_q == km1) begin
          // minimum has reached the end of the active chain
          if (v_q > min_tok.val) begin
            wr_vld = 1'b1;
          end
          state_d = last_q ? tks_pkg::ST_CLOSE : tks_pkg::ST_IDLE;
        end else begin
          step_d = step_q + tks_pkg::IDX_W'(1);
        end
      end
      tks_pkg::ST_CLOSE: begin
        load_cmd = 1'b1;
        cnt_d    = '0;
        step_d   = '0;
        r_d      = '0;
        if (cnt_q < {k_q, 1'b0}) begin
          err_d   = 1'b1;
          state_d = tks_pkg::ST_EMIT;
        end else begin
          err_d   = 1'b0;
          state_d = tks_pkg::ST_RANK;
        end
      end
      tks_pkg::ST_RANK: begin
        rank_cmd = 1'b1;
        if (step_q == km1) begin
          state_d = tks_pkg::ST_EMIT;
        end else begin
          step_d = step_q + tks_pkg::IDX_W'(1);
        end
      end
      tks_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (err_q || (r_q == km1)) begin
            state_d = tks_pkg::ST_IDLE;
          end else begin
            r_d = r_q + tks_pkg::IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = tks_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tks_pkg::ST_IDLE;
      keep_q  <= tks_pkg::CFG_W'(1);
      k_q     <= tks_pkg::K_W'(1);
      cnt_q   <= '0;
      step_q  <= '0;
      r_q     <= '0;
      err_q   <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        keep_q <= cfg_wdata_i;
      end
      k_q    <= k_d;
      cnt_q  <= cnt_d;
      step_q <= step_d;
      r_q    <= r_d;
      err_q  <= err_d;
      last_q <= last_d;
    end
  end

  // Pending value
  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  // Cell chain: min token runs forward, ring copy closes at cell k-1
  for (genvar i = 0; i < tks_pkg::MAX_KEEP; i++) begin : g_cell
    assign cmd[i] = '{we: wr_vld && (wr_idx == tks_pkg::IDX_W'(i)),
                      load: load_cmd, rank_en: rank_cmd};
    if (i == 0) begin : g_head
      assign tok_in[i]  = '{vld: 1'b0, val: '0, idx: '0};
      assign circ_in[i] = circ_out[km1];
    end else begin : g_body
      assign tok_in[i]  = tok_out[i-1];
      assign circ_in[i] = circ_out[i-1];
    end
    tks_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (tks_pkg::IDX_W'(i)),
      .cmd_i      (cmd[i]),
      .wr_data_i  (wr_data),
      .tok_i      (tok_in[i]),
      .tok_o      (tok_out[i]),
      .circ_i     (circ_in[i]),
      .circ_o     (circ_out[i]),
      .val_o      (cell_val[i]),
      .rank_o     (cell_rank[i])
    );
  end

  // Pick the active cell whose rank matches the beat being sent
  always_comb begin
    emit_val = '0;
    for (int i = 0; i < tks_pkg::MAX_KEEP; i++) begin
      if ((tks_pkg::K_W'(i) < k_q) && (cell_rank[i] == r_q)) begin
        emit_val = emit_val | cell_val[i];
      end
    end
  end

  // Result beat contents
  always_comb begin
    if (err_q) begin
      load_val    = '0;
      load_rank   = '0;
      load_status = tks_pkg::STATUS_SHORT;
      load_last   = 1'b1;
    end else begin
      load_val    = emit_val;
      load_rank   = tks_pkg::RANK_W'(r_q);
      load_status = tks_pkg::STATUS_OK;
      load_last   = (r_q == km1);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_val_q    <= load_val;
      out_rank_q   <= load_rank;
      out_status_q <= load_status;
      out_last_q   <= load_last;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{PAD_W{1'b0}}, out_rank_q, out_val_q};
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule
